### src/matrix_chain_order_cost_unit_macros.svh
// Assertion macros for the matrix chain cost unit.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef MATRIX_CHAIN_ORDER_COST_UNIT_MACROS_SVH
`define MATRIX_CHAIN_ORDER_COST_UNIT_MACROS_SVH

// same-cycle implication
`define MCOC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcoc assertion failed");

// next-cycle implication
`define MCOC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcoc assertion failed");

`endif

### src/mcoc_pkg.sv
// Shared types and constants for the matrix chain cost unit.
// No dependencies.
`default_nettype none
package mcoc_pkg;

    localparam int DIM_W        = 12;
    localparam int COST_W       = 48;
    localparam int MAX_DIMS_DEF = 16;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // controller -> datapath
    typedef struct packed {
        logic load_dim;   // item accepted: store dimension
        logic clr_cnt;    // chain finished: restart count
        logic load_pi;    // capture p[i-1] from the dimension read port
        logic load_pj;    // capture p[j] from the dimension read port
        logic issue;      // launch one split step into the pipeline
        logic wr_cost;    // write best into the cost table at (i, j)
        logic clr_best;   // short chain: result is zero
        logic load_out;   // move best into the output register
    } mcoc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pipe_busy;
    } mcoc_stat_t;

endpackage
`default_nettype wire

### src/mcoc_dim_if.sv
// Input channel: one chain dimension per item.
// Uses mcoc_pkg for field widths.
`default_nettype none
interface mcoc_dim_if;
    logic                       valid;
    logic                       ready;
    logic [mcoc_pkg::DIM_W-1:0] dim_value;
    logic                       last_dim;

    modport source (output valid, output dim_value, output last_dim, input ready);
    modport sink   (input valid, input dim_value, input last_dim, output ready);
endinterface
`default_nettype wire

### src/mcoc_cost_if.sv
// Output channel: minimum cost of one chain per item.
// Uses mcoc_pkg for field widths.
`default_nettype none
interface mcoc_cost_if;
    logic                        valid;
    logic                        ready;
    logic [mcoc_pkg::COST_W-1:0] min_cost;
    logic                        cost_saturated;

    modport source (output valid, output min_cost, output cost_saturated, input ready);
    modport sink   (input valid, input min_cost, input cost_saturated, output ready);
endinterface
`default_nettype wire

### src/mcoc_ctrl.sv
// Sequencer for the matrix chain cost unit: loading, table walk, result hand-off.
// Depends on mcoc_pkg.
`default_nettype none
module mcoc_ctrl #(
    parameter int MAX_DIMS = mcoc_pkg::MAX_DIMS_DEF,
    localparam int IW = $clog2(MAX_DIMS),
    localparam int CW = $clog2(MAX_DIMS + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_last,
    output logic                     in_ready,
    input  wire logic                out_ready,
    output logic                     out_valid,
    input  wire logic [CW-1:0]       dim_count,
    input  wire mcoc_pkg::mcoc_stat_t stat,
    output mcoc_pkg::mcoc_cmd_t      cmd,
    output logic [IW-1:0]            i_idx,
    output logic [IW-1:0]            j_idx,
    output logic [IW-1:0]            k_idx,
    output logic [IW-1:0]            dim_raddr
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_RD_PI = 3'd2;
    localparam logic [2:0] ST_RD_PJ = 3'd3;
    localparam logic [2:0] ST_ISSUE = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] m_reg, m_next;
    logic          out_valid_reg, out_valid_next;
    logic          slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        m_next         = m_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        dim_raddr      = k_reg;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_dim = 1'b1;
                    if (in_last)
                        state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (dim_count < CW'(3))
                begin
                    cmd.clr_best = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    m_next     = IW'(dim_count - CW'(1));
                    i_next     = IW'(dim_count - CW'(2));
                    j_next     = IW'(dim_count - CW'(1));
                    state_next = ST_RD_PI;
                end
            end
            ST_RD_PI:
            begin
                dim_raddr  = IW'(i_reg - IW'(1));
                state_next = ST_RD_PJ;
            end
            ST_RD_PJ:
            begin
                dim_raddr   = j_reg;
                cmd.load_pi = 1'b1;
                k_next      = i_reg;
                state_next  = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                dim_raddr   = k_reg;
                cmd.issue   = 1'b1;
                cmd.load_pj = (k_reg == i_reg);
                if (IW'(k_reg + IW'(1)) == j_reg)
                    state_next = ST_DRAIN;
                else
                    k_next = IW'(k_reg + IW'(1));
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    if (i_reg == IW'(1) && j_reg == m_reg)
                        state_next = ST_DONE;
                    else
                    begin
                        cmd.wr_cost = 1'b1;
                        state_next  = ST_RD_PI;
                        if (j_reg == m_reg)
                        begin
                            // next row up: first cell is (i-1, i)
                            i_next = IW'(i_reg - IW'(1));
                            j_next = i_reg;
                        end
                        else
                            j_next = IW'(j_reg + IW'(1));
                    end
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.clr_cnt    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            m_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            m_reg         <= m_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign i_idx     = i_reg;
    assign j_idx     = j_reg;
    assign k_idx     = k_reg;

endmodule
`default_nettype wire

### src/mcoc_dpath.sv
// Datapath of the matrix chain cost unit: dimension store, cost table,
// four-stage split-step pipeline, running minimum and output register.
// Depends on mcoc_pkg.
`default_nettype none
module mcoc_dpath #(
    parameter int MAX_DIMS = mcoc_pkg::MAX_DIMS_DEF,
    localparam int IW = $clog2(MAX_DIMS),
    localparam int CW = $clog2(MAX_DIMS + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mcoc_pkg::mcoc_cmd_t         cmd,
    input  wire logic [IW-1:0]               i_idx,
    input  wire logic [IW-1:0]               j_idx,
    input  wire logic [IW-1:0]               k_idx,
    input  wire logic [IW-1:0]               dim_raddr,
    input  wire logic [mcoc_pkg::DIM_W-1:0]  dim_value,
    output mcoc_pkg::mcoc_stat_t             stat,
    output logic [CW-1:0]                    dim_count,
    output logic [mcoc_pkg::COST_W-1:0]      min_cost,
    output logic                             cost_saturated
);

    localparam int DW = mcoc_pkg::DIM_W;
    localparam int KW = mcoc_pkg::COST_W;
    localparam int TDEPTH = 1 << (2 * IW);

    // storage
    logic [DW-1:0] dim_mem [MAX_DIMS];
    logic [KW-1:0] cost_mem [TDEPTH];
    logic [DW-1:0] dim_rd_reg;
    logic [KW-1:0] rd_a_reg, rd_b_reg;
    logic [CW-1:0] cnt_reg;

    // cell constants
    logic [DW-1:0] pi_reg, pj_reg;

    // pipeline
    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic          f1_reg, f2_reg, f3_reg, f4_reg;
    logic          zk1_reg, zj1_reg;
    logic [2*DW-1:0] prod1_reg;
    logic [KW-1:0] s1_reg, s1b_reg, s2_reg;
    logic          o1_reg, o1b_reg, o2_reg;
    logic [3*DW-1:0] prod_reg;

    logic [KW-1:0] best_reg;
    logic          best_ovf_reg;
    logic [KW-1:0] min_cost_reg;
    logic          sat_reg;

    logic [KW-1:0] op_a, op_b;
    logic [KW:0]   sum1, sum2;
    logic          take;
    logic [IW-1:0] k_plus;

    assign k_plus = IW'(k_idx + IW'(1));

    // dimension store and count
    always_ff @(posedge clk)
    begin
        if (cmd.load_dim && cnt_reg < CW'(MAX_DIMS))
            dim_mem[cnt_reg[IW-1:0]] <= dim_value;
        dim_rd_reg <= dim_mem[dim_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.clr_cnt)
            cnt_reg <= '0;
        else if (cmd.load_dim && cnt_reg < CW'(MAX_DIMS))
            cnt_reg <= CW'(cnt_reg + CW'(1));
    end

    // cost table: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.wr_cost)
            cost_mem[{i_idx, j_idx}] <= best_reg;
        rd_a_reg <= cost_mem[{i_idx, k_idx}];
        rd_b_reg <= cost_mem[{k_plus, j_idx}];
    end

    // diagonal entries are zero and never stored
    assign op_a = zk1_reg ? '0 : rd_a_reg;
    assign op_b = zj1_reg ? '0 : rd_b_reg;
    assign sum1 = {1'b0, op_a} + {1'b0, op_b};
    assign sum2 = {1'b0, s1b_reg} + {{(KW + 1 - 3 * DW){1'b0}}, prod_reg};
    assign take = f4_reg || (s2_reg < best_reg) ||
                  ((s2_reg == best_reg) && !o2_reg && best_ovf_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pi)
            pi_reg <= dim_rd_reg;
        if (cmd.load_pj)
            pj_reg <= dim_rd_reg;
        // issue
        f1_reg  <= (k_idx == i_idx);
        zk1_reg <= (k_idx == i_idx);
        zj1_reg <= (k_plus == j_idx);
        // stage 1: first product, sub-cost sum
        prod1_reg <= pi_reg * dim_rd_reg;
        s1_reg    <= sum1[KW] ? mcoc_pkg::COST_MAX : sum1[KW-1:0];
        o1_reg    <= sum1[KW];
        f2_reg    <= f1_reg;
        // stage 2: second product
        prod_reg <= prod1_reg * pj_reg;
        s1b_reg  <= s1_reg;
        o1b_reg  <= o1_reg;
        f3_reg   <= f2_reg;
        // stage 3: add product
        s2_reg <= sum2[KW] ? mcoc_pkg::COST_MAX : sum2[KW-1:0];
        o2_reg <= o1b_reg || sum2[KW];
        f4_reg <= f3_reg;
        // stage 4: running minimum
        if (cmd.clr_best)
        begin
            best_reg     <= '0;
            best_ovf_reg <= 1'b0;
        end
        else if (v4_reg && take)
        begin
            best_reg     <= s2_reg;
            best_ovf_reg <= o2_reg;
        end
        if (cmd.load_out)
        begin
            min_cost_reg <= best_reg;
            sat_reg      <= best_ovf_reg;
        end
    end

    assign stat.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
    assign dim_count      = cnt_reg;
    assign min_cost       = min_cost_reg;
    assign cost_saturated = sat_reg;

endmodule
`default_nettype wire

### src/matrix_chain_order_cost_unit.sv
// Top level of the matrix chain cost unit; instantiates mcoc_ctrl and mcoc_dpath.
// Depends on mcoc_pkg, mcoc_dim_if, mcoc_cost_if and the assertion macro header.
`default_nettype none
`include "matrix_chain_order_cost_unit_macros.svh"

// Minimum scalar multiplication count of a matrix chain. Dimensions arrive one
// item per cycle on dim_in; the item with last_dim set closes the chain and one
// result item follows on cost_out. Dimensions beyond MAX_DIMS are dropped; a
// chain of fewer than three dimensions yields cost 0. Costs are clamped to
// 2^48-1 and cost_saturated flags a clamp caused by overflow. While the table
// is filled dim_in is not ready. Within one table entry one split step enters
// the multiply/add pipeline per cycle; each entry first fetches its outer
// dimensions and then drains the four-stage pipeline, since the next entry of
// a row reads the one just finished. A finished result waits in the output
// register while the next chain loads. Tables need no clearing: only entries
// written for the current chain are read.
module matrix_chain_order_cost_unit #(
    parameter int MAX_DIMS = mcoc_pkg::MAX_DIMS_DEF
) (
    input wire logic    clk,
    input wire logic    rst_n,
    mcoc_dim_if.sink    dim_in,
    mcoc_cost_if.source cost_out
);

    localparam int IW = $clog2(MAX_DIMS);
    localparam int CW = $clog2(MAX_DIMS + 1);

    mcoc_pkg::mcoc_cmd_t  cmd;
    mcoc_pkg::mcoc_stat_t stat;
    logic [CW-1:0]        dim_count;
    logic [IW-1:0]        i_idx, j_idx, k_idx, dim_raddr;

    // sequencer: owns handshakes and the (i, j, k) walk
    mcoc_ctrl #(
        .MAX_DIMS (MAX_DIMS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dim_in.valid),
        .in_last   (dim_in.last_dim),
        .in_ready  (dim_in.ready),
        .out_ready (cost_out.ready),
        .out_valid (cost_out.valid),
        .dim_count (dim_count),
        .stat      (stat),
        .cmd       (cmd),
        .i_idx     (i_idx),
        .j_idx     (j_idx),
        .k_idx     (k_idx),
        .dim_raddr (dim_raddr)
    );

    // storage, split-step pipeline, running minimum, output register
    mcoc_dpath #(
        .MAX_DIMS (MAX_DIMS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .i_idx          (i_idx),
        .j_idx          (j_idx),
        .k_idx          (k_idx),
        .dim_raddr      (dim_raddr),
        .dim_value      (dim_in.dim_value),
        .stat           (stat),
        .dim_count      (dim_count),
        .min_cost       (cost_out.min_cost),
        .cost_saturated (cost_out.cost_saturated)
    );

    // a table entry is written only once all its split steps are folded in
    `MCOC_ASSERT_NOW(a_write_after_drain, cmd.wr_cost, !stat.pipe_busy)
    // a result loaded into the output register is offered next cycle
    `MCOC_ASSERT_NEXT(a_result_offered, cmd.load_out, cost_out.valid)
    // dimension count never passes the store depth
    `MCOC_ASSERT_NOW(a_count_bound, 1'b1, dim_count <= CW'(MAX_DIMS))
    // no split step is in flight while items are being taken
    `MCOC_ASSERT_NOW(a_idle_while_loading, dim_in.ready, !stat.pipe_busy && !cmd.issue)

endmodule
`default_nettype wire
